@@ src/tpps_pkg.sv @@
// Package: constants, microcode types and control store for the prescaler solver.
`default_nettype none
package tpps_pkg;

  // Source clock and samples clocked out per waveform period
  localparam int CLOCK_HZ           = 60000000;
  localparam int SAMPLES_PER_PERIOD = 100;

  // Timer limits
  localparam int MIN_PRESCALE = 6;
  localparam int RELOAD_MAX   = 16'hFFFF;

  // Field widths
  localparam int FREQ_W = 20;
  localparam int OUT_W  = 16;

  // Datapath widths, all derived from the constants above
  localparam int SAMP_W = $clog2(SAMPLES_PER_PERIOD + 1);
  localparam int RATE_W = FREQ_W + SAMP_W;
  localparam int TOT_W  = $clog2(CLOCK_HZ + 1);
  localparam int PRE_W  = TOT_W - 15;
  localparam int DIV_W  = (RATE_W > PRE_W) ? RATE_W : PRE_W;
  localparam int CNT_W  = $clog2(TOT_W + 1);

  // Control store geometry
  localparam int UCODE_DEPTH = 8;
  localparam int PC_W        = $clog2(UCODE_DEPTH);

  // Datapath operations
  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_MUL,
    OP_LOAD1,
    OP_LOAD2,
    OP_STEP,
    OP_WAIT,
    OP_EMIT
  } uop_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_ERR,
    COND_DIV_BUSY,
    COND_OUT_FULL
  } ucond_t;

  typedef struct packed {
    uop_t          op;
    ucond_t        cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Step addresses
  localparam logic [PC_W-1:0] PC_ACCEPT = PC_W'(0);
  localparam logic [PC_W-1:0] PC_MUL    = PC_W'(1);
  localparam logic [PC_W-1:0] PC_LOAD1  = PC_W'(2);
  localparam logic [PC_W-1:0] PC_DIV1   = PC_W'(3);
  localparam logic [PC_W-1:0] PC_LOAD2  = PC_W'(4);
  localparam logic [PC_W-1:0] PC_DIV2   = PC_W'(5);
  localparam logic [PC_W-1:0] PC_WAIT   = PC_W'(6);
  localparam logic [PC_W-1:0] PC_EMIT   = PC_W'(7);

  // Control store: one word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_ACCEPT: w = '{op: OP_ACCEPT, cond: COND_NO_INPUT, target: PC_ACCEPT};
      PC_MUL:    w = '{op: OP_MUL,    cond: COND_ERR,      target: PC_WAIT};
      PC_LOAD1:  w = '{op: OP_LOAD1,  cond: COND_NONE,     target: PC_ACCEPT};
      PC_DIV1:   w = '{op: OP_STEP,   cond: COND_DIV_BUSY, target: PC_DIV1};
      PC_LOAD2:  w = '{op: OP_LOAD2,  cond: COND_NONE,     target: PC_ACCEPT};
      PC_DIV2:   w = '{op: OP_STEP,   cond: COND_DIV_BUSY, target: PC_DIV2};
      PC_WAIT:   w = '{op: OP_WAIT,   cond: COND_OUT_FULL, target: PC_WAIT};
      PC_EMIT:   w = '{op: OP_EMIT,   cond: COND_ALWAYS,   target: PC_ACCEPT};
      default:   w = '{op: OP_WAIT,   cond: COND_ALWAYS,   target: PC_ACCEPT};
    endcase
    return w;
  endfunction

endpackage : tpps_pkg
`default_nettype wire

@@ src/timer_prescaler_period_solver.sv @@
// Top level: microcoded solver for timer prescaler and auto-reload settings.
// A zero frequency skips both divides and jumps straight to the output wait step.
// One word in flight: the next word can be accepted in the cycle after emit; a
// finished word waits in the output register while the next word is taken.
// Most of the run time goes to the shared one-bit-per-cycle restoring divider, run once
// for CLOCK_HZ / rate and once for total / prescaler.
// Reset clears the step counter to the accept step and drops out_valid.
`default_nettype none
module timer_prescaler_period_solver
  import tpps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [FREQ_W-1:0] freq_hz,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [OUT_W-1:0]       prescale_minus_one,
  output logic [OUT_W-1:0]       reload_minus_one,
  output logic                   bad_freq
);

  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_next;
  ucode_t            uw;
  logic              take_jump;

  logic [FREQ_W-1:0] freq;
  logic              err;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W-1:0]  rem;
  logic [TOT_W-1:0]  quo;
  logic [CNT_W-1:0]  cnt;
  logic [PRE_W-1:0]  pre;

  logic [DIV_W:0]    shifted;
  logic              fits;
  logic [DIV_W:0]    diff;
  logic [PRE_W-1:0]  pre_raw;
  logic [PRE_W-1:0]  pre_calc;
  logic [OUT_W-1:0]  reload_clamp;
  logic              reload_zero;
  logic              out_full;

  // Fetch the control word
  assign uw       = ucode_rom(pc);
  assign out_full = out_valid && out_stall;
  assign in_stall = (uw.op != OP_ACCEPT);

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      COND_NONE:     take_jump = 1'b0;
      COND_ALWAYS:   take_jump = 1'b1;
      COND_NO_INPUT: take_jump = !in_valid;
      COND_ERR:      take_jump = err;
      COND_DIV_BUSY: take_jump = (cnt != CNT_W'(1));
      COND_OUT_FULL: take_jump = out_full;
      default:       take_jump = 1'b0;
    endcase
  end

  // Advance or jump the step counter
  always_comb begin
    if (take_jump) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_ACCEPT;
    end else begin
      pc <= pc_next;
    end
  end

  // Restoring divide step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem, quo[TOT_W-1]};
  assign fits    = (shifted >= {1'b0, divisor});
  assign diff    = shifted - {1'b0, divisor};

  // Prescaler from the total divide: max(MIN_PRESCALE, (total >> 16) + 1)
  assign pre_raw  = PRE_W'(quo[TOT_W-1:16]) + PRE_W'(1);
  assign pre_calc = (pre_raw < PRE_W'(MIN_PRESCALE)) ? PRE_W'(MIN_PRESCALE) : pre_raw;

  // Clamp the reload value to 16 bits
  assign reload_zero  = (quo == '0);
  assign reload_clamp = (quo > TOT_W'(RELOAD_MAX)) ? OUT_W'(RELOAD_MAX) : quo[OUT_W-1:0];

  // Datapath driven by the control word
  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_ACCEPT: begin
        freq <= freq_hz;
        err  <= (freq_hz == '0);
      end
      OP_MUL: begin
        divisor <= DIV_W'(RATE_W'(freq) * RATE_W'(SAMPLES_PER_PERIOD));
      end
      OP_LOAD1: begin
        quo <= TOT_W'(CLOCK_HZ);
        rem <= '0;
        cnt <= CNT_W'(TOT_W);
      end
      OP_LOAD2: begin
        pre     <= pre_calc;
        divisor <= DIV_W'(pre_calc);
        rem     <= '0;
        cnt     <= CNT_W'(TOT_W);
      end
      OP_STEP: begin
        quo <= {quo[TOT_W-2:0], fits};
        rem <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        cnt <= cnt - CNT_W'(1);
      end
      OP_WAIT, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: load on emit, drop once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_EMIT) begin
      if (err || reload_zero) begin
        prescale_minus_one <= '0;
        reload_minus_one   <= '0;
        bad_freq           <= 1'b1;
      end else begin
        prescale_minus_one <= OUT_W'(pre - PRE_W'(1));
        reload_minus_one   <= reload_clamp - OUT_W'(1);
        bad_freq           <= 1'b0;
      end
    end
  end

endmodule : timer_prescaler_period_solver
`default_nettype wire

@@ src/tpps_checker.sv @@
// Checker: port-level assertions for the prescaler solver, bound to the top level.
`default_nettype none
module tpps_checker
  import tpps_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [FREQ_W-1:0] freq_hz,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [OUT_W-1:0]  prescale_minus_one,
  input wire logic [OUT_W-1:0]  reload_minus_one,
  input wire logic              bad_freq
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(prescale_minus_one)
      && $stable(reload_minus_one) && $stable(bad_freq))
    else $error("stalled result word changed or dropped");

  // Block further input right after a word is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in flight");

  // Zero both settings on an error word
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_freq |-> prescale_minus_one == '0 && reload_minus_one == '0)
    else $error("error word carries nonzero settings");

  // Keep the prescaler at or above its floor on a good word
  a_pre_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_freq |-> prescale_minus_one >= OUT_W'(MIN_PRESCALE - 1))
    else $error("prescaler below minimum");

  // Hold a stalled input word until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(freq_hz))
    else $error("stalled input word changed or dropped");

endmodule : tpps_checker

bind timer_prescaler_period_solver tpps_checker u_tpps_checker (.*);
`default_nettype wire

@@ verif/timer_prescaler_period_solver_tb.sv @@
// Testbench: checks prescaler and auto-reload words from the solver against a local predictor.
module timer_prescaler_period_solver_tb;
  import tpps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RST_CYCLES   = 10;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [FREQ_W-1:0] FREQ_TOP = {FREQ_W{1'b1}};

  // One expected solver word
  typedef struct packed {
    logic [OUT_W-1:0] prescale;
    logic [OUT_W-1:0] reload;
    logic             bad;
  } timer_setting_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [FREQ_W-1:0] freq_hz;
  logic              out_valid;
  logic              out_stall;
  logic [OUT_W-1:0]  prescale_minus_one;
  logic [OUT_W-1:0]  reload_minus_one;
  logic              bad_freq;

  timer_setting_t pending_settings[$];
  int             mismatches = 0;
  int             cycle_count = 0;
  bit             idle_on = 1'b1;
  bit             hold_off_req = 1'b0;

  timer_prescaler_period_solver uut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .freq_hz            (freq_hz),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .prescale_minus_one (prescale_minus_one),
    .reload_minus_one   (reload_minus_one),
    .bad_freq           (bad_freq)
  );

  // Free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Work out the timer setting for one requested frequency
  function automatic timer_setting_t solve_timer_setting(input logic [FREQ_W-1:0] f);
    timer_setting_t   s;
    longint unsigned  sample_rate;
    longint unsigned  divide_total;
    longint unsigned  prescale;
    longint unsigned  period;
    s = '{prescale: '0, reload: '0, bad: 1'b1};
    // Zero frequency has no period at all
    if (f == '0) return s;
    sample_rate  = 64'(f) * 64'(SAMPLES_PER_PERIOD);
    divide_total = 64'(CLOCK_HZ) / sample_rate;
    prescale     = (divide_total >> 16) + 64'd1;
    if (prescale < 64'(MIN_PRESCALE)) prescale = 64'(MIN_PRESCALE);
    period = divide_total / prescale;
    // Frequency too high: the period rounds down to nothing
    if (period == 64'd0) return s;
    if (period > 64'(RELOAD_MAX)) period = 64'(RELOAD_MAX);
    s.prescale = OUT_W'(prescale - 64'd1);
    s.reload   = OUT_W'(period - 64'd1);
    s.bad      = 1'b0;
    return s;
  endfunction

  // Drive out_stall: random bursts, or one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk) begin
    timer_setting_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_settings.size() == 0) begin
        $error("unexpected word: prescale_minus_one=%0d reload_minus_one=%0d bad_freq=%0b",
               prescale_minus_one, reload_minus_one, bad_freq);
        mismatches++;
      end else begin
        want = pending_settings.pop_front();
        if (prescale_minus_one !== want.prescale) begin
          $error("prescale_minus_one: expected %0d, actual %0d", want.prescale,
                 prescale_minus_one);
          mismatches++;
        end
        if (reload_minus_one !== want.reload) begin
          $error("reload_minus_one: expected %0d, actual %0d", want.reload, reload_minus_one);
          mismatches++;
        end
        if (bad_freq !== want.bad) begin
          $error("bad_freq: expected %0b, actual %0b", want.bad, bad_freq);
          mismatches++;
        end
      end
    end
  end

  // Offer one word, with an optional idle burst first; return once accepted
  task automatic send_word(input logic [FREQ_W-1:0] f);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    freq_hz  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_settings.push_back(solve_timer_setting(f));
  endtask

  // Drop valid and hold until every expected word is back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
  endtask

  // Pick a frequency, weighted toward the serviceable range and its upper edge
  function automatic logic [FREQ_W-1:0] pick_freq();
    int unsigned w;
    case ($urandom_range(0, 9))
      0:       return FREQ_W'($urandom_range(0, 3));
      1, 2:    return FREQ_W'($urandom_range(1, 64));
      3, 4: begin
        w = $urandom_range(1, 17);
        return FREQ_W'($urandom & ((32'd1 << w) - 32'd1));
      end
      5:       return FREQ_W'($urandom_range(99990, 100010));
      6, 7:    return FREQ_W'($urandom_range(1, 100000));
      default: return FREQ_W'($urandom_range(0, FREQ_TOP));
    endcase
  endfunction

  // Extremes, the zero and too-high cases, and the prescaler step above six
  task automatic test_directed_edges();
    logic [FREQ_W-1:0] edge_freqs[$];
    edge_freqs = '{20'd0, 20'd1, 20'd2, 20'd3, 20'd9, 20'd10, 20'd100, 20'd1000,
                   20'd12345, 20'd65536, 20'd85714, 20'd85715, 20'd99999, 20'd100000,
                   20'd100001, 20'd100002, 20'd131072, 20'h55555, 20'hAAAAA,
                   20'h80000, FREQ_TOP};
    foreach (edge_freqs[i]) send_word(edge_freqs[i]);
    pause_until_drained();
  endtask

  // Random frequencies under random idling on both sides
  task automatic test_random_mix(input int count);
    repeat (count) send_word(pick_freq());
  endtask

  // Hold the output long enough that the solver backs up into its input
  task automatic test_output_hold_off();
    hold_off_req = 1'b1;
    repeat (8) send_word(pick_freq());
    pause_until_drained();
  endtask

  // Send short groups, draining completely between them
  task automatic test_drain_pause();
    repeat (4) begin
      repeat ($urandom_range(3, 10)) send_word(pick_freq());
      pause_until_drained();
    end
  endtask

  // Back-to-back words with no idling anywhere
  task automatic test_steady_stream(input int count);
    idle_on = 1'b0;
    repeat (count) send_word(pick_freq());
  endtask

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    freq_hz  <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_random_mix(700);
    test_output_hold_off();
    test_drain_pause();
    test_random_mix(100);
    test_steady_stream(350);

    // Drain, then watch for stray words
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_settings.size() != 0) begin
      $error("%0d expected words never arrived", pending_settings.size());
      mismatches++;
    end
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
